>>> design/coalescing_job_queue_core_assert.svh
// Assertion macros for the queue RTL, included by the queue core.
`ifndef COALESCING_JOB_QUEUE_CORE_ASSERT_SVH
`define COALESCING_JOB_QUEUE_CORE_ASSERT_SVH

`ifndef SYNTH
// Plain property check, disabled while reset is asserted.
`define CJQ_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Condition in one cycle implies a consequence in the next.
`define CJQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define CJQ_ASSERT(lbl, clk, rstn, prop, msg)
`define CJQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

>>> design/cjq_pkg.sv
package cjq_pkg;

  localparam int QueueDepth = 16;
  localparam int IdxW       = $clog2(QueueDepth);
  localparam int CntW       = $clog2(QueueDepth + 1);
  localparam int WordW      = 32;
  localparam int DataW      = 3 * WordW;

  // Operation selected by the input word
  typedef enum logic [1:0] {
    MODE_PUSH        = 2'd0,
    MODE_PUSH_UNIQUE = 2'd1,
    MODE_REPLACE     = 2'd2,
    MODE_DRAIN       = 2'd3
  } mode_e;

  // Result status carried with each output word
  typedef enum logic [2:0] {
    ST_APPENDED  = 3'd0,
    ST_REPLACED  = 3'd1,
    ST_DUPLICATE = 3'd2,
    ST_FULL      = 3'd3,
    ST_DRAINED   = 3'd4,
    ST_EMPTY     = 3'd5
  } status_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load_item;
    logic exec_push;
    logic exec_empty;
    logic exec_drain;
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_drain;
    logic count_zero;
    logic drain_last;
    logic out_free;
  } dp_stat_t;

endpackage

>>> design/coalescing_job_queue_core.sv
// Coalescing job queue.
// Slave stream: tdata = {job_payload, function_id, creator_id}, tuser = mode
// (push anyway, push unless duplicate, replace or push, drain).
// Master stream: tdata = {out_payload, out_function, out_creator}, tuser = status,
// tlast marks the final word caused by one input word.
// A push runs from accept to result in the output register as follows: at accept the key
// is compared against all stored entries in parallel and the match vector is registered;
// in S_LOOK, once the output register is free, the oldest match is picked and the entry storage updated.
// A drain of n entries passes S_LOOK and then S_DRAIN, which gives one word per cycle while
// the output register is free, oldest entry first; an empty drain gives one word from S_LOOK.
// The next input word is taken once the previous one has loaded its last result,
// even while that result still waits in the output register.
// If the receiver stalls, the output register holds its word and the block stops
// in place until it is taken. Reset empties the queue and clears all valids;
// the block accepts words in the first cycle after reset.
module coalescing_job_queue_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  input  logic [cjq_pkg::DataW-1:0] s_axis_tdata_i,  // creator_id, function_id, job_payload
  input  logic [1:0]                s_axis_tuser_i,  // mode
  output logic                      m_axis_tvalid_o,
  input  logic                      m_axis_tready_i,
  output logic [cjq_pkg::DataW-1:0] m_axis_tdata_o,  // out_creator, out_function, out_payload
  output logic [2:0]                m_axis_tuser_o,  // status
  output logic                      m_axis_tlast_o
);

`include "coalescing_job_queue_core_assert.svh"

  cjq_pkg::ctrl_cmd_t cmd;
  cjq_pkg::dp_stat_t  stat;

  cjq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  cjq_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .in_tdata_i   (s_axis_tdata_i),
    .in_tuser_i   (s_axis_tuser_i),
    .out_tvalid_o (m_axis_tvalid_o),
    .out_tready_i (m_axis_tready_i),
    .out_tdata_o  (m_axis_tdata_o),
    .out_tuser_o  (m_axis_tuser_o),
    .out_tlast_o  (m_axis_tlast_o)
  );

  // Checks
  `CJQ_ASSERT(a_cmd_onehot, clk_i, rst_ni, $onehot0({cmd.load_item, cmd.exec_push, cmd.exec_empty, cmd.exec_drain}), "more than one datapath command")
  `CJQ_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o, "input accepted while an item is in work")
  `CJQ_ASSERT(a_push_result, clk_i, rst_ni, !(m_axis_tvalid_o && (m_axis_tuser_o == cjq_pkg::ST_APPENDED || m_axis_tuser_o == cjq_pkg::ST_REPLACED || m_axis_tuser_o == cjq_pkg::ST_DUPLICATE || m_axis_tuser_o == cjq_pkg::ST_FULL || m_axis_tuser_o == cjq_pkg::ST_EMPTY)) || (m_axis_tlast_o && m_axis_tdata_o == '0), "single result word without last or with data")
  `CJQ_ASSERT(a_drain_ctrl, clk_i, rst_ni, !cmd.exec_drain || !stat.count_zero, "drain of an empty queue")

endmodule

>>> design/cjq_ctrl.sv
module cjq_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  cjq_pkg::dp_stat_t  stat_i,
  output cjq_pkg::ctrl_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_LOOK  = 3'b010,
    S_DRAIN = 3'b100
  } state_e;

  state_e state_q, state_d;

  // Next state and command decode
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.load_item = in_valid_i;
        if (in_valid_i) state_d = S_LOOK;
      end
      S_LOOK: begin
        if (stat_i.is_drain) begin
          if (!stat_i.count_zero) begin
            state_d = S_DRAIN;
          end else if (stat_i.out_free) begin
            cmd_o.exec_empty = 1'b1;
            state_d          = S_IDLE;
          end
        end else if (stat_i.out_free) begin
          cmd_o.exec_push = 1'b1;
          state_d         = S_IDLE;
        end
      end
      S_DRAIN: begin
        if (stat_i.out_free) begin
          cmd_o.exec_drain = 1'b1;
          if (stat_i.drain_last) state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> design/cjq_dpath.sv
module cjq_dpath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  cjq_pkg::ctrl_cmd_t          cmd_i,
  output cjq_pkg::dp_stat_t           stat_o,
  input  logic [cjq_pkg::DataW-1:0]   in_tdata_i,  // creator_id, function_id, job_payload
  input  logic [1:0]                  in_tuser_i,  // mode
  output logic                        out_tvalid_o,
  input  logic                        out_tready_i,
  output logic [cjq_pkg::DataW-1:0]   out_tdata_o, // out_creator, out_function, out_payload
  output logic [2:0]                  out_tuser_o, // status
  output logic                        out_tlast_o
);

  localparam int W = cjq_pkg::WordW;

  // Entry storage, valid below count_q
  logic [W-1:0] ent_cr_q [cjq_pkg::QueueDepth];
  logic [W-1:0] ent_fn_q [cjq_pkg::QueueDepth];
  logic [W-1:0] ent_pl_q [cjq_pkg::QueueDepth];
  logic [cjq_pkg::CntW-1:0] count_q, count_d;
  logic [cjq_pkg::IdxW-1:0] drain_idx_q, drain_idx_d;

  // Latched item and its key match vector
  cjq_pkg::mode_e                mode_q;
  logic [W-1:0]                  cr_q, fn_q, pl_q;
  logic [cjq_pkg::QueueDepth-1:0] match_q, match_d;

  // Output register
  logic                     out_valid_q, out_valid_d;
  cjq_pkg::status_e         out_status_q, status_d;
  logic [cjq_pkg::DataW-1:0] out_data_q;
  logic                     out_last_q;

  logic                     full, any_hit, app_en, rep_en, drain_last;
  logic [cjq_pkg::IdxW-1:0] hit_idx, app_idx;

  // Parallel key compare against the stored entries
  always_comb begin
    for (int i = 0; i < cjq_pkg::QueueDepth; i++) begin
      match_d[i] = (cjq_pkg::CntW'(i) < count_q)
                && (ent_cr_q[i] == in_tdata_i[W-1:0])
                && (ent_fn_q[i] == in_tdata_i[2*W-1:W]);
    end
  end

  // Oldest matching entry
  always_comb begin
    hit_idx = '0;
    for (int i = cjq_pkg::QueueDepth - 1; i >= 0; i--) begin
      if (match_q[i]) hit_idx = cjq_pkg::IdxW'(i);
    end
  end

  assign any_hit    = |match_q;
  assign full       = (count_q == cjq_pkg::CntW'(cjq_pkg::QueueDepth));
  assign app_idx    = count_q[cjq_pkg::IdxW-1:0];
  assign drain_last = ((cjq_pkg::CntW'(drain_idx_q) + cjq_pkg::CntW'(1)) == count_q);

  // Push outcome
  always_comb begin
    app_en   = 1'b0;
    rep_en   = 1'b0;
    status_d = cjq_pkg::ST_APPENDED;
    if (mode_q != cjq_pkg::MODE_PUSH && any_hit) begin
      if (mode_q == cjq_pkg::MODE_PUSH_UNIQUE) begin
        status_d = cjq_pkg::ST_DUPLICATE;
      end else begin
        status_d = cjq_pkg::ST_REPLACED;
        rep_en   = 1'b1;
      end
    end else if (full) begin
      status_d = cjq_pkg::ST_FULL;
    end else begin
      app_en = 1'b1;
    end
  end

  // Count and drain pointer
  always_comb begin
    count_d     = count_q;
    drain_idx_d = drain_idx_q;
    if (cmd_i.load_item) drain_idx_d = '0;
    if (cmd_i.exec_push && app_en) count_d = count_q + cjq_pkg::CntW'(1);
    if (cmd_i.exec_drain) begin
      if (drain_last) begin
        count_d     = '0;
        drain_idx_d = '0;
      end else begin
        drain_idx_d = drain_idx_q + cjq_pkg::IdxW'(1);
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_tready_i) out_valid_d = 1'b0;
    if (cmd_i.exec_push || cmd_i.exec_empty || cmd_i.exec_drain) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      drain_idx_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      drain_idx_q <= drain_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Item latch and entry writes
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      mode_q  <= cjq_pkg::mode_e'(in_tuser_i);
      cr_q    <= in_tdata_i[W-1:0];
      fn_q    <= in_tdata_i[2*W-1:W];
      pl_q    <= in_tdata_i[3*W-1:2*W];
      match_q <= match_d;
    end
    if (cmd_i.exec_push && app_en) begin
      ent_cr_q[app_idx] <= cr_q;
      ent_fn_q[app_idx] <= fn_q;
      ent_pl_q[app_idx] <= pl_q;
    end
    if (cmd_i.exec_push && rep_en) ent_pl_q[hit_idx] <= pl_q;
  end

  // Output word load
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec_push) begin
      out_status_q <= status_d;
      out_data_q   <= '0;
      out_last_q   <= 1'b1;
    end else if (cmd_i.exec_empty) begin
      out_status_q <= cjq_pkg::ST_EMPTY;
      out_data_q   <= '0;
      out_last_q   <= 1'b1;
    end else if (cmd_i.exec_drain) begin
      out_status_q <= cjq_pkg::ST_DRAINED;
      out_data_q   <= {ent_pl_q[drain_idx_q], ent_fn_q[drain_idx_q], ent_cr_q[drain_idx_q]};
      out_last_q   <= drain_last;
    end
  end

  assign stat_o.is_drain   = (mode_q == cjq_pkg::MODE_DRAIN);
  assign stat_o.count_zero = (count_q == '0);
  assign stat_o.drain_last = drain_last;
  assign stat_o.out_free   = !out_valid_q || out_tready_i;

  assign out_tvalid_o = out_valid_q;
  assign out_tdata_o  = out_data_q;
  assign out_tuser_o  = out_status_q;
  assign out_tlast_o  = out_last_q;

endmodule

>>> dv/coalescing_job_queue_core_tb.sv
module coalescing_job_queue_core_tb;
  import cjq_pkg::*;

  // One result word as the block should deliver it
  typedef struct {
    status_e     status;
    logic [31:0] creator;
    logic [31:0] func;
    logic [31:0] payload;
    logic        last;
  } job_result_t;

  logic             clk_i;
  logic             rst_ni;
  logic             s_axis_tvalid;
  logic             s_axis_tready_o;
  logic [DataW-1:0] s_axis_tdata;   // creator_id, function_id, job_payload
  logic [1:0]       s_axis_tuser;   // mode
  logic             m_axis_tvalid_o;
  logic             m_axis_tready;
  logic [DataW-1:0] m_axis_tdata_o; // out_creator, out_function, out_payload
  logic [2:0]       m_axis_tuser_o; // status
  logic             m_axis_tlast_o;

  coalescing_job_queue_core u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // Shadow copy of the job queue
  logic [31:0] shadow_creator [QueueDepth];
  logic [31:0] shadow_func    [QueueDepth];
  logic [31:0] shadow_payload [QueueDepth];
  int          shadow_count;

  job_result_t pending_results[$];
  int          err_count;
  bit          src_gap_en;
  bit          sink_gap_en;
  int          sink_hold_cycles;

  initial begin
    clk_i = 1'b0;
  end

  always #4 clk_i = ~clk_i;

  // Watchdog
  initial begin
    #5000000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic void queue_result(status_e st, logic [31:0] cr, logic [31:0] fn,
                                       logic [31:0] pl, logic lst);
    job_result_t r;
    r.status  = st;
    r.creator = cr;
    r.func    = fn;
    r.payload = pl;
    r.last    = lst;
    pending_results.push_back(r);
  endfunction

  // Work out the results of one accepted job word and update the shadow queue
  function automatic void predict_job(mode_e mode, logic [31:0] cr, logic [31:0] fn,
                                      logic [31:0] pl);
    int      hit;
    status_e st;
    hit = -1;
    if (mode == MODE_DRAIN) begin
      if (shadow_count == 0) begin
        queue_result(ST_EMPTY, '0, '0, '0, 1'b1);
      end else begin
        for (int i = 0; i < shadow_count; i++)
          queue_result(ST_DRAINED, shadow_creator[i], shadow_func[i], shadow_payload[i],
                       i == shadow_count - 1);
        shadow_count = 0;
      end
      return;
    end
    // Oldest matching key, only looked up by the coalescing modes
    if (mode != MODE_PUSH) begin
      for (int i = 0; i < shadow_count; i++)
        if (hit < 0 && shadow_creator[i] == cr && shadow_func[i] == fn) hit = i;
    end
    if (hit >= 0 && mode == MODE_PUSH_UNIQUE) begin
      st = ST_DUPLICATE;
    end else if (hit >= 0) begin
      shadow_payload[hit] = pl;
      st = ST_REPLACED;
    end else if (shadow_count >= QueueDepth) begin
      st = ST_FULL;
    end else begin
      shadow_creator[shadow_count] = cr;
      shadow_func[shadow_count]    = fn;
      shadow_payload[shadow_count] = pl;
      shadow_count++;
      st = ST_APPENDED;
    end
    queue_result(st, '0, '0, '0, 1'b1);
  endfunction

  // Offer one job word after a random gap and wait until it is taken
  task automatic send_job(input mode_e mode, input logic [31:0] cr, input logic [31:0] fn,
                          input logic [31:0] pl);
    int gap;
    gap = src_gap_en ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {pl, fn, cr};
    s_axis_tuser  <= mode;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    predict_job(mode, cr, fn, pl);
  endtask

  // Sender pause: stop offering until every result is back, then let the block settle
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Receiver: random stall per word, plus a long hold when a test asks for one
  initial begin
    int gap;
    m_axis_tready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (sink_hold_cycles > 0) begin
        m_axis_tready <= 1'b0;
        repeat (sink_hold_cycles) @(posedge clk_i);
        sink_hold_cycles = 0;
      end
      gap = sink_gap_en ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid_o) @(posedge clk_i);
    end
  end

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      err_count++;
    end
  endfunction

  // Compare each delivered word with the oldest outstanding prediction
  always @(posedge clk_i) begin
    job_result_t r;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result word: status %0d", m_axis_tuser_o);
        err_count++;
      end else begin
        r = pending_results.pop_front();
        check_field("status", 32'(r.status), 32'(m_axis_tuser_o));
        check_field("out_creator", r.creator, m_axis_tdata_o[31:0]);
        check_field("out_function", r.func, m_axis_tdata_o[63:32]);
        check_field("out_payload", r.payload, m_axis_tdata_o[95:64]);
        check_field("last", 32'(r.last), 32'(m_axis_tlast_o));
      end
    end
  end

  // Empty drain, extreme keys, repeated key, full queue in every mode, full drain
  task automatic test_edges();
    send_job(MODE_DRAIN, $urandom, $urandom, $urandom);
    send_job(MODE_PUSH, '0, '0, '0);
    send_job(MODE_PUSH, '1, '1, '1);
    send_job(MODE_PUSH, '0, '0, 32'h1111_1111);
    for (int i = 3; i < QueueDepth; i++)
      send_job(MODE_PUSH, $urandom, 32'(i), $urandom);
    send_job(MODE_PUSH, 32'h5a5a_5a5a, 32'hffff_0000, $urandom);
    send_job(MODE_PUSH_UNIQUE, 32'h5a5a_5a5a, 32'hffff_0001, $urandom);
    send_job(MODE_PUSH_UNIQUE, '1, '1, 32'hdead_beef);
    // two entries share the zero key: only the older one changes
    send_job(MODE_REPLACE, '0, '0, 32'ha5a5_a5a5);
    send_job(MODE_REPLACE, 32'h5a5a_5a5a, 32'hffff_0002, $urandom);
    send_job(MODE_DRAIN, '1, '1, '1);
    wait_drained();
  endtask

  // Hold the receiver off while pushes keep coming, so input stalls
  task automatic test_backpressure();
    sink_hold_cycles = 400;
    for (int i = 0; i < 30; i++)
      send_job(MODE_PUSH, $urandom, $urandom, $urandom);
    wait_drained();
    send_job(MODE_DRAIN, $urandom, $urandom, $urandom);
    wait_drained();
  endtask

  // Random traffic over a small key pool so duplicates and partial matches are common
  task automatic test_random_traffic();
    logic [31:0] cr_pool [3];
    logic [31:0] fn_pool [3];
    int          drain_pct;
    int          pick;
    mode_e       mode;
    logic [31:0] cr;
    logic [31:0] fn;
    drain_pct = 15;
    for (int i = 0; i < 115; i++) begin
      // new stretch: fresh keys, idling pattern and drain rate
      if (i % 35 == 0) begin
        foreach (cr_pool[k]) cr_pool[k] = $urandom;
        foreach (fn_pool[k]) fn_pool[k] = $urandom;
        src_gap_en  = $urandom_range(0, 2) != 0;
        sink_gap_en = $urandom_range(0, 2) != 0;
        drain_pct   = ($urandom_range(0, 1) != 0) ? 15 : 3;
      end
      pick = $urandom_range(0, 99);
      if (pick < drain_pct)
        mode = MODE_DRAIN;
      else
        mode = mode_e'($urandom_range(0, 2));
      if ($urandom_range(0, 9) < 7) begin
        cr = cr_pool[$urandom_range(0, 2)];
        fn = fn_pool[$urandom_range(0, 2)];
      end else begin
        cr = $urandom;
        fn = $urandom;
      end
      send_job(mode, cr, fn, $urandom);
    end
    send_job(MODE_DRAIN, $urandom, $urandom, $urandom);
    wait_drained();
  endtask

  initial begin
    err_count        = 0;
    shadow_count     = 0;
    sink_hold_cycles = 0;
    src_gap_en       = 1'b1;
    sink_gap_en      = 1'b1;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_edges();
    test_backpressure();
    test_random_traffic();

    repeat (20) @(posedge clk_i);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
